>>> hw/rtl/gbs_pkg.sv
// Package for the greedy box suppression block.
// Holds shared defaults, the controller state type and the control/status structs.
// No dependencies.
package gbs_pkg;

  // Defaults for the top level parameters
  localparam int unsigned MAX_KEPT_DEF   = 64;
  localparam int unsigned MAX_SET_DEF    = 1024;
  localparam int unsigned COORD_BITS_DEF = 16;

  // Threshold register
  localparam int unsigned           LIMIT_W     = 9;
  localparam logic [LIMIT_W-1:0]    LIMIT_RESET = 9'd115;

  // Q12.4: one whole pixel is 1 << FRAC_BITS
  localparam int unsigned FRAC_BITS = 4;
  localparam int          ONE_PIXEL = 1 << FRAC_BITS;

  // Threshold is in units of 1/256
  localparam int unsigned OVL_SHIFT = 8;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_AREA,
    ST_SCAN,
    ST_DRAIN,
    ST_COMMIT
  } state_e;

  typedef struct packed {
    logic load;    // capture the box, start a new set if flagged
    logic area;    // area of the new box, reset the scan
    logic scan;    // issue store reads
    logic commit;  // store survivor, register the result
  } cmd_t;

  typedef struct packed {
    logic idx_end;    // every kept box has been issued
    logic pipe_busy;  // compare pipeline still holds work
  } sts_t;

endpackage

>>> hw/rtl/gbs_ctrl.sv
// Controller state machine of the greedy box suppression block.
// Sequences load, area, scan, drain and commit for each box.
// Depends on gbs_pkg.
module gbs_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  gbs_pkg::sts_t sts_i,
  output gbs_pkg::cmd_t cmd_o,
  output logic          busy_o
);

  gbs_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gbs_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      gbs_pkg::ST_IDLE: begin
        if (start_i) state_d = gbs_pkg::ST_AREA;
      end
      gbs_pkg::ST_AREA:  state_d = gbs_pkg::ST_SCAN;
      gbs_pkg::ST_SCAN: begin
        if (sts_i.idx_end) state_d = gbs_pkg::ST_DRAIN;
      end
      gbs_pkg::ST_DRAIN: begin
        if (!sts_i.pipe_busy) state_d = gbs_pkg::ST_COMMIT;
      end
      gbs_pkg::ST_COMMIT: state_d = gbs_pkg::ST_IDLE;
      default:            state_d = gbs_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o  = '0;
    busy_o = 1'b1;
    case (state_q)
      gbs_pkg::ST_IDLE: begin
        busy_o     = 1'b0;
        cmd_o.load = start_i;
      end
      gbs_pkg::ST_AREA:   cmd_o.area   = 1'b1;
      gbs_pkg::ST_SCAN:   cmd_o.scan   = 1'b1;
      gbs_pkg::ST_DRAIN:  cmd_o        = '0;
      gbs_pkg::ST_COMMIT: cmd_o.commit = 1'b1;
      default:            busy_o       = 1'b0;
    endcase
  end

  // a scan never starts with work left in the pipeline
  a_scan_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == gbs_pkg::ST_AREA) |-> !sts_i.pipe_busy)
    else $error("pipeline busy at start of scan");

  // commit only once the pipeline has drained
  a_commit_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |-> !sts_i.pipe_busy)
    else $error("commit with comparisons in flight");

  // commit lasts exactly one cycle
  a_commit_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |=> !cmd_o.commit)
    else $error("commit held for more than one cycle");

endmodule

>>> hw/rtl/gbs_dp.sv
// Datapath of the greedy box suppression block: box registers, kept box store,
// six-stage compare pipeline, counters and the result register.
// Depends on gbs_pkg.
module gbs_dp #(
  parameter int unsigned MAX_KEPT   = gbs_pkg::MAX_KEPT_DEF,
  parameter int unsigned MAX_SET    = gbs_pkg::MAX_SET_DEF,
  parameter int unsigned COORD_BITS = gbs_pkg::COORD_BITS_DEF,
  localparam int unsigned CB        = COORD_BITS,
  localparam int unsigned CW        = $clog2(MAX_KEPT + 1),
  localparam int unsigned IXW       = $clog2(MAX_SET)
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  gbs_pkg::cmd_t                  cmd_i,
  output gbs_pkg::sts_t                  sts_o,
  input  logic [gbs_pkg::LIMIT_W-1:0]    limit_i,
  input  logic                           first_of_set_i,
  input  logic signed [CB-1:0]           left_x_i,
  input  logic signed [CB-1:0]           top_y_i,
  input  logic signed [CB-1:0]           right_x_i,
  input  logic signed [CB-1:0]           bottom_y_i,
  output logic                           done_o,
  output logic                           keep_o,
  output logic [IXW-1:0]                 box_index_o,
  output logic [CW-1:0]                  kept_total_o,
  output logic                           store_full_o
);

  localparam int unsigned AW     = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
  localparam int unsigned BOX_W  = 4 * CB;
  localparam int unsigned AREA_W = 2 * CB + 2;       // signed area
  localparam int unsigned IW     = 2 * CB + 2;       // unsigned intersection
  localparam int unsigned UW     = 2 * CB + 4;       // signed union
  localparam int unsigned PW     = gbs_pkg::LIMIT_W + UW;
  localparam int unsigned DW     = CB + 2;           // side length before clamp

  // Current box and set bookkeeping
  logic signed [CB-1:0]     cur_lx_q, cur_ty_q, cur_rx_q, cur_by_q;
  logic signed [AREA_W-1:0] area_q;
  logic [IXW-1:0]           pos_q, cur_pos_q;
  logic [CW-1:0]            count_q, rd_idx_q;
  logic                     keep_q;

  // Store
  logic [BOX_W-1:0]         box_mem [MAX_KEPT];
  logic [AREA_W-1:0]        area_mem [MAX_KEPT];
  logic                     issue;
  logic                     store_we;

  // Pipeline
  logic [BOX_W-1:0]         rd_box_q;
  logic signed [AREA_W-1:0] rd_area_q, ka2_q, ka3_q;
  logic [CB:0]              w_q, h_q;
  logic [IW-1:0]            inter3_q, inter4_q, inter5_q;
  logic signed [UW-1:0]     uni_q;
  logic [PW-1:0]            prod_q;
  logic                     nonneg_q;
  logic                     v1_q, v2_q, v3_q, v4_q, v5_q;

  // Result register
  logic                     done_q, keep_out_q, full_out_q;
  logic [IXW-1:0]           index_out_q;
  logic [CW-1:0]            total_out_q;

  logic signed [CB:0]       dx, dy;
  logic signed [CB-1:0]     k_lx, k_ty, k_rx, k_by;
  logic signed [CB-1:0]     min_r, max_l, min_b, max_t;
  logic signed [DW-1:0]     w_raw, h_raw;
  logic signed [UW-1:0]     uni_d;
  logic                     room;
  logic                     suppress;

  assign issue    = cmd_i.scan && (rd_idx_q != count_q);
  assign room     = (count_q != CW'(MAX_KEPT));
  assign store_we = cmd_i.commit && keep_q && room;

  assign sts_o.idx_end   = (rd_idx_q == count_q);
  assign sts_o.pipe_busy = v1_q | v2_q | v3_q | v4_q | v5_q;

  // New box area, no extra pixel
  assign dx = (CB+1)'(cur_rx_q) - (CB+1)'(cur_lx_q);
  assign dy = (CB+1)'(cur_by_q) - (CB+1)'(cur_ty_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cur_lx_q <= left_x_i;
      cur_ty_q <= top_y_i;
      cur_rx_q <= right_x_i;
      cur_by_q <= bottom_y_i;
    end
    if (cmd_i.area) begin
      area_q <= AREA_W'(dx) * AREA_W'(dy);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      pos_q     <= '0;
      cur_pos_q <= '0;
      rd_idx_q  <= '0;
      keep_q    <= 1'b1;
    end else begin
      if (cmd_i.load) begin
        if (first_of_set_i) begin
          count_q   <= '0;
          cur_pos_q <= '0;
        end else begin
          cur_pos_q <= pos_q;
        end
      end
      if (cmd_i.area) begin
        rd_idx_q <= '0;
        keep_q   <= 1'b1;
      end else if (issue) begin
        rd_idx_q <= rd_idx_q + CW'(1);
      end
      if (v5_q && suppress) keep_q <= 1'b0;
      if (cmd_i.commit) begin
        if (store_we) count_q <= count_q + CW'(1);
        pos_q <= (cur_pos_q == IXW'(MAX_SET - 1)) ? '0 : cur_pos_q + IXW'(1);
      end
    end
  end

  // Kept box store, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (store_we) begin
      box_mem[count_q[AW-1:0]]  <= {cur_by_q, cur_rx_q, cur_ty_q, cur_lx_q};
      area_mem[count_q[AW-1:0]] <= area_q;
    end
    if (issue) begin
      rd_box_q  <= box_mem[rd_idx_q[AW-1:0]];
      rd_area_q <= area_mem[rd_idx_q[AW-1:0]];
    end
  end

  // Stage 2: overlap sides, +1 pixel, clamped at zero
  assign k_lx  = rd_box_q[CB-1:0];
  assign k_ty  = rd_box_q[2*CB-1:CB];
  assign k_rx  = rd_box_q[3*CB-1:2*CB];
  assign k_by  = rd_box_q[4*CB-1:3*CB];
  assign min_r = (cur_rx_q < k_rx) ? cur_rx_q : k_rx;
  assign max_l = (cur_lx_q > k_lx) ? cur_lx_q : k_lx;
  assign min_b = (cur_by_q < k_by) ? cur_by_q : k_by;
  assign max_t = (cur_ty_q > k_ty) ? cur_ty_q : k_ty;
  assign w_raw = DW'(min_r) - DW'(max_l) + DW'(gbs_pkg::ONE_PIXEL);
  assign h_raw = DW'(min_b) - DW'(max_t) + DW'(gbs_pkg::ONE_PIXEL);

  // Stage 4: union
  assign uni_d = UW'(area_q) + UW'(ka3_q) - $signed({2'b00, inter3_q});

  // Stage 6: inter*256 > limit*union, only for a non-negative union
  assign suppress = nonneg_q && ((PW'(inter5_q) << gbs_pkg::OVL_SHIFT) > prod_q);

  always_ff @(posedge clk_i) begin
    w_q      <= w_raw[DW-1] ? '0 : w_raw[CB:0];
    h_q      <= h_raw[DW-1] ? '0 : h_raw[CB:0];
    ka2_q    <= rd_area_q;
    inter3_q <= IW'(w_q) * IW'(h_q);
    ka3_q    <= ka2_q;
    inter4_q <= inter3_q;
    uni_q    <= uni_d;
    inter5_q <= inter4_q;
    nonneg_q <= !uni_q[UW-1];
    prod_q   <= PW'(limit_i) * PW'(uni_q[UW-2:0]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      v1_q <= issue;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  // Result register, shown for one cycle after commit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= cmd_i.commit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      keep_out_q  <= keep_q;
      full_out_q  <= keep_q && !room;
      index_out_q <= cur_pos_q;
      total_out_q <= store_we ? count_q + CW'(1) : count_q;
    end
  end

  assign done_o       = done_q;
  assign keep_o       = keep_out_q;
  assign store_full_o = full_out_q;
  assign box_index_o  = index_out_q;
  assign kept_total_o = total_out_q;

  // the kept count never passes the store depth
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_KEPT))
    else $error("kept count beyond store depth");

  // the scan never reads past the kept boxes
  a_read_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    issue |-> (rd_idx_q < count_q))
    else $error("store read beyond kept boxes");

  // a write only goes to a free entry and grows the count by one
  a_write_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    store_we |=> (count_q == $past(count_q) + CW'(1)))
    else $error("store write without count update");

endmodule

>>> hw/rtl/greedy_box_suppression_top.sv
// Top level of the greedy box suppression block.
// Holds the threshold register and joins gbs_ctrl and gbs_dp.
// Depends on gbs_pkg, gbs_ctrl, gbs_dp.

// Greedy non-maximum suppression, one box per command. Boxes of a set are
// presented in descending confidence order as signed Q12.4 corners; a box is
// taken at the clock edge with start_i high and busy_o low, and first_of_set_i
// clears the kept store and restarts box_index_o at zero before that box is
// handled. Each box is checked against every box kept so far in its set and
// dropped when inter*256 > overlap_limit*union (union below zero never
// suppresses). The result appears for exactly one cycle with done_o high and
// there is no back-pressure: sample it on that cycle or lose it. After the
// accepting edge a box passes the area, scan, drain and commit states before
// done_o; the scan length follows the kept count and the single read port
// of the kept box store, which feeds one comparison a cycle into a six-stage
// compare pipeline that then has to drain. busy_o drops as done_o rises, so
// the next box can be taken in the cycle its predecessor's result is shown.
// The threshold is written through cfg_valid_i/cfg_data_i, always ready;
// write it only while busy_o is low and no result is pending. A survivor found
// with the store full is reported with keep_o and store_full_o set but is not
// stored. No clearing pass is needed after reset.
module greedy_box_suppression_top #(
  parameter int unsigned MAX_KEPT   = gbs_pkg::MAX_KEPT_DEF,
  parameter int unsigned MAX_SET    = gbs_pkg::MAX_SET_DEF,
  parameter int unsigned COORD_BITS = gbs_pkg::COORD_BITS_DEF,
  localparam int unsigned CW        = $clog2(MAX_KEPT + 1),
  localparam int unsigned IXW       = $clog2(MAX_SET)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // command channel
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic                          first_of_set_i,
  input  logic signed [COORD_BITS-1:0]  left_x_i,
  input  logic signed [COORD_BITS-1:0]  top_y_i,
  input  logic signed [COORD_BITS-1:0]  right_x_i,
  input  logic signed [COORD_BITS-1:0]  bottom_y_i,
  // result strobe
  output logic                          done_o,
  output logic                          keep_o,
  output logic [IXW-1:0]                box_index_o,
  output logic [CW-1:0]                 kept_total_o,
  output logic                          store_full_o,
  // threshold write channel
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [gbs_pkg::LIMIT_W-1:0]   cfg_data_i
);

  logic [gbs_pkg::LIMIT_W-1:0] limit_q;
  gbs_pkg::cmd_t               cmd;
  gbs_pkg::sts_t               sts;

  // Threshold register; a transfer is taken on any cycle
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= gbs_pkg::LIMIT_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      limit_q <= cfg_data_i;
    end
  end

  gbs_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy_o)
  );

  gbs_dp #(
    .MAX_KEPT   (MAX_KEPT),
    .MAX_SET    (MAX_SET),
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .limit_i        (limit_q),
    .first_of_set_i (first_of_set_i),
    .left_x_i       (left_x_i),
    .top_y_i        (top_y_i),
    .right_x_i      (right_x_i),
    .bottom_y_i     (bottom_y_i),
    .done_o         (done_o),
    .keep_o         (keep_o),
    .box_index_o    (box_index_o),
    .kept_total_o   (kept_total_o),
    .store_full_o   (store_full_o)
  );

  // an accepted box keeps the block busy on the next cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("block not busy after a box was taken");

  // results are one-cycle strobes and never back to back
  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe held");

  // a full store is reported only for a survivor with the store at depth
  a_full_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && store_full_o) |-> (keep_o && (kept_total_o == CW'(MAX_KEPT))))
    else $error("store full flag inconsistent");

endmodule

>>> bench/gbs_suppression_check_pkg.sv
// Expected-result tracker for the greedy box suppression testbench.
// Holds its own copy of the kept store and the threshold, and the queue of verdicts.
// Depends on gbs_pkg.
`timescale 1ns / 1ps

package gbs_suppression_check_pkg;

  localparam int unsigned COORD_W  = gbs_pkg::COORD_BITS_DEF;
  localparam int unsigned IDX_W    = $clog2(gbs_pkg::MAX_SET_DEF);
  localparam int unsigned CNT_W    = $clog2(gbs_pkg::MAX_KEPT_DEF + 1);
  localparam int unsigned KEPT_MAX = gbs_pkg::MAX_KEPT_DEF;
  localparam int unsigned SET_MAX  = gbs_pkg::MAX_SET_DEF;
  localparam longint      PIXEL    = 16;   // one whole pixel in Q12.4
  localparam longint      IOU_ONE  = 256;  // threshold scale

  typedef struct {
    longint lx;
    longint ty;
    longint rx;
    longint by;
  } corners_t;

  typedef struct {
    logic             keep;
    logic [IDX_W-1:0] index;
    logic [CNT_W-1:0] total;
    logic             full;
  } verdict_t;

  class suppression_tracker;
    corners_t                    kept_boxes[$];
    longint                      kept_areas[$];
    int unsigned                 position;
    logic [gbs_pkg::LIMIT_W-1:0] limit;
    verdict_t                    expected_verdicts[$];
    int unsigned                 errors;

    function new();
      position = 0;
      limit    = gbs_pkg::LIMIT_RESET;
      errors   = 0;
    endfunction

    function void set_limit(logic [gbs_pkg::LIMIT_W-1:0] value);
      limit = value;
    endfunction

    function int unsigned pending();
      return expected_verdicts.size();
    endfunction

    // Greedy pass of one box against the kept store; queues its verdict.
    function void note_box(bit first, logic signed [COORD_W-1:0] lx,
                           logic signed [COORD_W-1:0] ty,
                           logic signed [COORD_W-1:0] rx,
                           logic signed [COORD_W-1:0] by);
      corners_t cur;
      longint   area, w, h, inter, uni;
      bit       keep;
      verdict_t v;
      if (first) begin
        kept_boxes.delete();
        kept_areas.delete();
        position = 0;
      end
      cur.lx = lx;
      cur.ty = ty;
      cur.rx = rx;
      cur.by = by;
      area = (cur.rx - cur.lx) * (cur.by - cur.ty);
      keep = 1'b1;
      foreach (kept_boxes[k]) begin
        w = ((cur.rx < kept_boxes[k].rx) ? cur.rx : kept_boxes[k].rx)
          - ((cur.lx > kept_boxes[k].lx) ? cur.lx : kept_boxes[k].lx) + PIXEL;
        h = ((cur.by < kept_boxes[k].by) ? cur.by : kept_boxes[k].by)
          - ((cur.ty > kept_boxes[k].ty) ? cur.ty : kept_boxes[k].ty) + PIXEL;
        if (w < 0) w = 0;
        if (h < 0) h = 0;
        inter = w * h;
        uni   = area + kept_areas[k] - inter;
        // negative union never suppresses
        if (uni >= 0 && inter * IOU_ONE > longint'(limit) * uni) keep = 1'b0;
      end
      v.keep  = keep;
      v.full  = 1'b0;
      v.index = position[IDX_W-1:0];
      if (keep) begin
        if (kept_boxes.size() < KEPT_MAX) begin
          kept_boxes = {kept_boxes, cur};
          kept_areas = {kept_areas, area};
        end else begin
          v.full = 1'b1;
        end
      end
      v.total  = CNT_W'(kept_boxes.size());
      position = (position + 1 >= SET_MAX) ? 0 : position + 1;
      expected_verdicts = {expected_verdicts, v};
    endfunction

    function void check_verdict(logic keep, logic [IDX_W-1:0] index,
                                logic [CNT_W-1:0] total, logic full);
      verdict_t v;
      if (expected_verdicts.size() == 0) begin
        $error("result strobe with no box outstanding");
        errors++;
        return;
      end
      v = expected_verdicts.pop_front();
      if (keep !== v.keep) begin
        $error("keep: expected %0d, actual %0d", v.keep, keep);
        errors++;
      end
      if (index !== v.index) begin
        $error("box_index: expected %0d, actual %0d", v.index, index);
        errors++;
      end
      if (total !== v.total) begin
        $error("kept_total: expected %0d, actual %0d", v.total, total);
        errors++;
      end
      if (full !== v.full) begin
        $error("store_full: expected %0d, actual %0d", v.full, full);
        errors++;
      end
    endfunction
  endclass

endpackage

>>> bench/greedy_box_suppression_top_test.sv
// Self-checking testbench for greedy_box_suppression_top.
// Drives boxes and threshold writes, checks every result strobe against the tracker.
// Depends on gbs_pkg, gbs_suppression_check_pkg and the block's RTL.
`timescale 1ns / 1ps

module greedy_box_suppression_top_test;

  localparam int unsigned COORD_W  = gbs_suppression_check_pkg::COORD_W;
  localparam int unsigned IDX_W    = gbs_suppression_check_pkg::IDX_W;
  localparam int unsigned CNT_W    = gbs_suppression_check_pkg::CNT_W;
  localparam int unsigned KEPT_MAX = gbs_suppression_check_pkg::KEPT_MAX;
  localparam int unsigned SET_MAX  = gbs_suppression_check_pkg::SET_MAX;
  localparam int unsigned LIMIT_W  = gbs_pkg::LIMIT_W;

  localparam int C_MAX = (1 << (COORD_W - 1)) - 1;
  localparam int C_MIN = -(1 << (COORD_W - 1));
  // worst-case latency from accept to done, used for the closing wait
  localparam int unsigned LAT_MAX = KEPT_MAX + 8;

  localparam logic [gbs_pkg::LIMIT_W-1:0] LIMIT_TABLE [6] = '{
    9'd0, 9'd256, 9'd511, 9'd128, gbs_pkg::LIMIT_RESET, 9'd1
  };

  logic                         clk_i          = 1'b0;
  logic                         rst_ni         = 1'b0;
  logic                         start_i        = 1'b0;
  logic                         first_of_set_i = 1'b0;
  logic signed [COORD_W-1:0]    left_x_i       = '0;
  logic signed [COORD_W-1:0]    top_y_i        = '0;
  logic signed [COORD_W-1:0]    right_x_i      = '0;
  logic signed [COORD_W-1:0]    bottom_y_i     = '0;
  logic                         cfg_valid_i    = 1'b0;
  logic [gbs_pkg::LIMIT_W-1:0]  cfg_data_i     = '0;
  logic                         busy_o;
  logic                         done_o;
  logic                         keep_o;
  logic [IDX_W-1:0]             box_index_o;
  logic [CNT_W-1:0]             kept_total_o;
  logic                         store_full_o;
  logic                         cfg_ready_o;

  gbs_suppression_check_pkg::suppression_tracker track = new();

  greedy_box_suppression_top uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .first_of_set_i (first_of_set_i),
    .left_x_i       (left_x_i),
    .top_y_i        (top_y_i),
    .right_x_i      (right_x_i),
    .bottom_y_i     (bottom_y_i),
    .done_o         (done_o),
    .keep_o         (keep_o),
    .box_index_o    (box_index_o),
    .kept_total_o   (kept_total_o),
    .store_full_o   (store_full_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i)
  );

  // 4 ns period
  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Results cannot be held off: each strobe is a transfer at the edge that
  // ends its cycle. Sampled at the edge, so we see pre-update values.
  always @(posedge clk_i) begin
    if (rst_ni && done_o === 1'b1) begin
      track.check_verdict(keep_o, box_index_o, kept_total_o, store_full_o);
    end
  end

  // Box transfer: start stays high after the accepting edge, so a caller that
  // sends straight on never drops and re-raises it in the same step.
  task automatic send_box(input bit first, input logic signed [COORD_W-1:0] lx,
                          input logic signed [COORD_W-1:0] ty,
                          input logic signed [COORD_W-1:0] rx,
                          input logic signed [COORD_W-1:0] by);
    start_i        <= 1'b1;
    first_of_set_i <= first;
    left_x_i       <= lx;
    top_y_i        <= ty;
    right_x_i      <= rx;
    bottom_y_i     <= by;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    track.note_box(first, lx, ty, rx, by);
  endtask

  // Sender stands back until every outstanding verdict has come in.
  task automatic drain();
    start_i <= 1'b0;
    while (track.pending() != 0 || busy_o !== 1'b0) @(posedge clk_i);
  endtask

  // Threshold write, only with the block idle. Every box yields a result, so
  // an empty queue means nothing is still in flight.
  task automatic write_limit(input logic [gbs_pkg::LIMIT_W-1:0] value);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    cfg_valid_i <= 1'b0;
    track.set_limit(value);
  endtask

  task automatic hold_off_sender(input bit enabled);
    if (enabled && $urandom_range(0, 2) == 0) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
  endtask

  function automatic logic signed [COORD_W-1:0] clamp_coord(input int v);
    if (v > C_MAX) return COORD_W'(C_MAX);
    if (v < C_MIN) return COORD_W'(C_MIN);
    return COORD_W'(v);
  endfunction

  // Mostly boxes scattered around a set centre; tight scatter gives heavy
  // overlap, wide scatter fills the store. The rest are raw noise, inverted
  // boxes and zero-width or zero-height boxes.
  task automatic random_box(input bit first, input int cx, input int cy,
                            input int spread);
    int                        pick, w, h, s, ox, oy;
    logic signed [COORD_W-1:0] lx, ty, rx, by, sw;
    pick = $urandom_range(0, 99);
    w    = $urandom_range(16, 1600);
    h    = $urandom_range(16, 1600);
    s    = $urandom_range(0, 1) ? spread : spread / 8 + 1;
    ox   = cx + int'($urandom_range(0, 2 * s)) - s;
    oy   = cy + int'($urandom_range(0, 2 * s)) - s;
    lx   = clamp_coord(ox - w / 2);
    rx   = clamp_coord(ox + w / 2);
    ty   = clamp_coord(oy - h / 2);
    by   = clamp_coord(oy + h / 2);
    if (pick >= 80 && pick < 88) begin
      lx = COORD_W'($urandom);
      ty = COORD_W'($urandom);
      rx = COORD_W'($urandom);
      by = COORD_W'($urandom);
    end else if (pick >= 88 && pick < 94) begin
      if ($urandom_range(0, 1)) begin
        sw = lx; lx = rx; rx = sw;
      end else begin
        sw = ty; ty = by; by = sw;
      end
    end else if (pick >= 94) begin
      if ($urandom_range(0, 1)) rx = lx;
      else by = ty;
    end
    send_box(first, lx, ty, rx, by);
  endtask

  initial begin
    int phase, n, sent, set_len, spread, cx, cy;
    bit idle_on;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: threshold still at its reset value, first box without a flag
    send_box(1'b0, 0, 0, 160, 160);
    send_box(1'b0, 0, 0, 160, 160);           // identical, dropped
    send_box(1'b0, 320, 0, 480, 160);         // disjoint
    send_box(1'b0, 176, 0, 300, 160);         // edges touch, zero overlap
    send_box(1'b0, C_MIN, C_MIN, C_MAX, C_MAX);
    send_box(1'b0, C_MAX, C_MIN, C_MIN, C_MAX); // inverted, negative area
    send_box(1'b1, 0, 0, 16, 16);
    send_box(1'b0, 0, 0, 0, 0);               // union zero, overlap positive
    send_box(1'b1, 0, 0, 0, 0);
    send_box(1'b0, 1000, 1000, 1000, 1000);   // union zero, no overlap
    send_box(1'b0, 0, 0, 0, 0);               // negative union with overlap
    send_box(1'b1, C_MAX, C_MAX, C_MAX, C_MAX);
    send_box(1'b0, C_MIN, C_MIN, C_MIN, C_MIN);
    write_limit(9'd0);                        // any overlap with a non-negative union suppresses
    send_box(1'b1, 0, 0, 1600, 1600);
    send_box(1'b0, 1590, 1590, 3000, 3000);
    send_box(1'b0, 5000, 5000, 6000, 6000);
    write_limit(9'd256);
    send_box(1'b1, 0, 0, 1600, 1600);
    send_box(1'b0, 0, 0, 1600, 1600);
    send_box(1'b0, 0, 0, 1600, 800);
    write_limit(9'd511);                      // about two: a box drops only if 256 * overlap exceeds 511 * union
    send_box(1'b1, 0, 0, 1600, 1600);
    send_box(1'b0, 0, 0, 1600, 1600);
    send_box(1'b0, 0, 0, 0, 0);

    // Random sets under a range of thresholds, extremes included
    for (phase = 0; phase < 6; phase++) begin
      write_limit(phase == 5 ? LIMIT_W'($urandom_range(0, 511)) : LIMIT_TABLE[phase]);
      sent = 0;
      while (sent < 55) begin
        set_len = ($urandom_range(0, 9) == 0) ? $urandom_range(66, 90)
                                               : $urandom_range(1, 30);
        case ($urandom_range(0, 3))
          0:       spread = 40;
          1:       spread = 400;
          2:       spread = 4000;
          default: spread = 30000;
        endcase
        cx      = int'($urandom_range(0, 40000)) - 20000;
        cy      = int'($urandom_range(0, 40000)) - 20000;
        idle_on = $urandom_range(0, 3) != 0;
        for (n = 0; n < set_len; n++) begin
          // the odd stray set start breaks a sequence mid-way
          random_box(n == 0 || $urandom_range(0, 49) == 0, cx, cy, spread);
          hold_off_sender(idle_on);
          sent++;
        end
        if ($urandom_range(0, 7) == 0) drain();
      end
    end

    // One long set: fills the store, then runs the position count past its wrap.
    // The tail of the run has no idling.
    write_limit(LIMIT_W'($urandom_range(64, 200)));
    for (n = 0; n < SET_MAX + 6; n++) begin
      random_box(n == 0, 0, 0, 30000);
      hold_off_sender(n < 800);
    end
    start_i <= 1'b0;

    for (n = 0; n < 4 * LAT_MAX && track.pending() != 0; n++) @(posedge clk_i);
    if (track.pending() != 0) begin
      $error("%0d results never arrived", track.pending());
      track.errors++;
    end
    repeat (2 * LAT_MAX) @(posedge clk_i);

    if (track.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog, well beyond the slowest correct run
  initial begin
    #3_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/gbs_pkg.sv
hw/rtl/gbs_ctrl.sv
hw/rtl/gbs_dp.sv
hw/rtl/greedy_box_suppression_top.sv
bench/gbs_suppression_check_pkg.sv
bench/greedy_box_suppression_top_test.sv
